FILE: sv/ppool_pkg.sv
// ============================================================================
// ppool_pkg
// Shared constants, types and helpers of the 2x2 stride-2 pooling stream core.
// ============================================================================
package ppool_pkg;

    // default sizes
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WIDTH_DEF   = 1024;

    // position counters and count registers
    localparam int POS_LIMIT    = 1024;
    localparam int POS_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(POS_LIMIT);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_MODE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH     = 2'd3;

    // pooling modes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    // configuration as seen by the datapath, counts already clamped
    typedef struct packed {
        logic                pool_mode;
        logic [CNT_BITS-1:0] channel_count;
        logic [CNT_BITS-1:0] map_height;
        logic [CNT_BITS-1:0] map_width;
    } t_cfg;

    // scan position info for the item at the input
    typedef struct packed {
        logic                in_win;
        logic                col_odd;
        logic                row_odd;
        logic                last_win;
        logic [POS_BITS-1:0] col;
    } t_scan_ctl;

    // zero acts as one, anything above the cap acts as the cap
    function automatic logic [CNT_BITS-1:0] clamp_count(
        input logic [CNT_BITS-1:0] v,
        input logic [CNT_BITS-1:0] cap
    );
        logic [CNT_BITS-1:0] res;
        if (v == '0) begin
            res = CNT_BITS'(1);
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: sv/ppool_if.sv
// ============================================================================
// ppool_if
// Valid/ready channels of the pooling core: samples, results, register writes.
// ============================================================================

// input sample channel
interface ppool_smp_if #(
    parameter int SAMPLE_BITS = ppool_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// pooled result channel
interface ppool_pool_if #(
    parameter int SAMPLE_BITS = ppool_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pooled_value;
    logic                          last_of_map;

    modport source (output valid, output pooled_value, output last_of_map, input ready);
    modport sink   (input valid, input pooled_value, input last_of_map, output ready);
endinterface

// register write channel
interface ppool_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ppool_pkg::CFG_IDX_BITS-1:0]    index;
    logic [ppool_pkg::CNT_BITS-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pool_2x2_stride2_stream_core.sv
// ============================================================================
// pool_2x2_stride2_stream_core
// 2x2 max/average pooling at stride 2 over a streamed feature map.
// ============================================================================
// Usage:
//   i_smp  : one signed Q8.8 sample per item, channel, row, column order.
//   o_pool : one pooled value per complete 2x2 window, same order;
//            last_of_map marks the final window of the whole map.
//   i_cfg  : register writes (mode, channel count, height, width), always
//            ready; write only while no item is in flight.
//   An odd last row or column of a channel is consumed and never pooled.
//   Throughput: one sample per cycle while no result is stalled. The result
//   of a window is valid in the cycle after its last sample is accepted,
//   from one register after a single pass of compare/add logic.
//   Upper-row pairs sit in a one-port store of (min(MAX_WIDTH,1024)+1)/2 entries,
//   read one item ahead so its registered data is ready for the lower row.
//   Reset: counters at the map origin, mode maximum, one channel of 2x2;
//   the store is not cleared, it is always written before its data is used.
//   Stall: the result register holds while o_pool.ready is low, and
//   i_smp.ready drops only while a result is waiting and not taken.
// ============================================================================
module pool_2x2_stride2_stream_core #(
    parameter int SAMPLE_BITS = ppool_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WIDTH   = ppool_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppool_cfg_if.sink     i_cfg,
    ppool_smp_if.sink     i_smp,
    ppool_pool_if.source  o_pool
);
    import ppool_pkg::*;

    t_cfg      cfg;
    t_scan_ctl ctl;
    logic      accept;
    logic      emit;

    ppool_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ppool_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (accept),
        .o_ctl   (ctl)
    );

    ppool_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (cfg.pool_mode),
        .i_ctl    (ctl),
        .i_smp    (i_smp),
        .o_pool   (o_pool),
        .o_accept (accept),
        .o_emit   (emit)
    );

    // a completed window shows up at the output on the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && emit |=> o_pool.valid)
        else $error("completed window did not reach the output");

    // no new item while a result is waiting and stalled
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pool.valid && !o_pool.ready |-> !i_smp.ready)
        else $error("item accepted over a stalled result");

    // results come only from the lower-right sample of a window
    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pool.valid && !(accept && emit) |=> !o_pool.valid)
        else $error("result appeared without an accepted item");

    // nothing is presented right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pool.valid)
        else $error("result valid after reset");

endmodule

FILE: sv/ppool_cfg.sv
// ============================================================================
// ppool_cfg
// Configuration registers; counts are clamped to their legal range on write.
// ============================================================================
module ppool_cfg #(
    parameter int MAX_WIDTH = ppool_pkg::MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ppool_cfg_if.sink        i_cfg,
    output ppool_pkg::t_cfg  o_cfg
);
    import ppool_pkg::*;

    localparam int WIDTH_CAP_I = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
    localparam logic [CNT_BITS-1:0] WIDTH_CAP = CNT_BITS'(WIDTH_CAP_I);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POOL_MODE:     n_cfg.pool_mode     = i_cfg.data[0];
                CFG_CHANNEL_COUNT: n_cfg.channel_count = clamp_count(i_cfg.data, CNT_LIMIT);
                CFG_MAP_HEIGHT:    n_cfg.map_height    = clamp_count(i_cfg.data, CNT_LIMIT);
                CFG_MAP_WIDTH:     n_cfg.map_width     = clamp_count(i_cfg.data, WIDTH_CAP);
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_mode     <= MODE_MAX;
            r_cfg.channel_count <= CNT_BITS'(1);
            r_cfg.map_height    <= CNT_BITS'(2);
            r_cfg.map_width     <= CNT_BITS'(2);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/ppool_scan.sv
// ============================================================================
// ppool_scan
// Column, row and channel counters that track where each sample sits.
// ============================================================================
module ppool_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppool_pkg::t_cfg       i_cfg,
    input  logic                  i_adv,
    output ppool_pkg::t_scan_ctl  o_ctl
);
    import ppool_pkg::*;

    logic [POS_BITS-1:0] r_col, r_row, r_chan;
    logic [POS_BITS-1:0] n_col, n_row, n_chan;

    logic [CNT_BITS-1:0] col_ext, row_ext, chan_ext;
    logic                col_end, row_end, chan_end;
    logic                col_has_pair, row_has_pair;
    logic                last_col, last_row;

    assign col_ext  = CNT_BITS'(r_col);
    assign row_ext  = CNT_BITS'(r_row);
    assign chan_ext = CNT_BITS'(r_chan);

    // window membership: the sample has a partner column and a partner row
    assign col_has_pair = (col_ext | CNT_BITS'(1)) < i_cfg.map_width;
    assign row_has_pair = (row_ext | CNT_BITS'(1)) < i_cfg.map_height;

    // position of the final window of the map
    assign last_col = (CNT_BITS'(r_col[POS_BITS-1:1]) + CNT_BITS'(1))
                      == (i_cfg.map_width >> 1);
    assign last_row = (CNT_BITS'(r_row[POS_BITS-1:1]) + CNT_BITS'(1))
                      == (i_cfg.map_height >> 1);

    assign col_end  = (col_ext + CNT_BITS'(1)) >= i_cfg.map_width;
    assign row_end  = (row_ext + CNT_BITS'(1)) >= i_cfg.map_height;
    assign chan_end = (chan_ext + CNT_BITS'(1)) >= i_cfg.channel_count;

    always_comb begin
        o_ctl.in_win   = col_has_pair && row_has_pair;
        o_ctl.col_odd  = r_col[0];
        o_ctl.row_odd  = r_row[0];
        o_ctl.last_win = chan_end && last_row && last_col;
        o_ctl.col      = r_col;
    end

    // raster advance
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_chan = r_chan;
        if (i_adv) begin
            if (col_end) begin
                n_col = '0;
                if (row_end) begin
                    n_row  = '0;
                    n_chan = chan_end ? '0 : POS_BITS'(r_chan + 1'b1);
                end else begin
                    n_row = POS_BITS'(r_row + 1'b1);
                end
            end else begin
                n_col = POS_BITS'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
        end
    end

endmodule

FILE: sv/ppool_core.sv
// ============================================================================
// ppool_core
// Pair combine, upper-row store, window combine and the result register.
// ============================================================================
module ppool_core #(
    parameter int SAMPLE_BITS = ppool_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WIDTH   = ppool_pkg::MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mode,
    input  ppool_pkg::t_scan_ctl  i_ctl,
    ppool_smp_if.sink             i_smp,
    ppool_pool_if.source          o_pool,
    output logic                  o_accept,
    output logic                  o_emit
);
    import ppool_pkg::*;

    localparam int WIDTH_CAP   = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
    localparam int STORE_DEPTH = (WIDTH_CAP + 1) / 2;
    localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PAIR_BITS   = SAMPLE_BITS + 1;
    localparam int TOT_BITS    = SAMPLE_BITS + 2;

    // upper-row store, one combined pair per window
    logic signed [PAIR_BITS-1:0] r_store [STORE_DEPTH];
    logic signed [PAIR_BITS-1:0] r_up;

    logic signed [SAMPLE_BITS-1:0] r_pair_partial;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_pooled;
    logic                          r_last;

    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [PAIR_BITS-1:0]   smp_ext, part_ext, pair_sum, pair_max, pair;
    logic signed [TOT_BITS-1:0]    tot;
    logic signed [PAIR_BITS-1:0]   win_max;
    logic signed [SAMPLE_BITS-1:0] res;
    logic [POS_BITS-2:0]           slot_full;
    logic [ADDR_BITS-1:0]          addr;
    logic                          pair_done, wr_upper;

    // handshake: take a new item whenever the result register frees up
    assign i_smp.ready = !r_out_valid || o_pool.ready;
    assign o_accept    = i_smp.valid && i_smp.ready;

    assign smp       = i_smp.sample;
    assign slot_full = i_ctl.col[POS_BITS-1:1];
    assign addr      = slot_full[ADDR_BITS-1:0];
    assign pair_done = i_ctl.in_win && i_ctl.col_odd;
    assign wr_upper  = pair_done && !i_ctl.row_odd;
    assign o_emit    = pair_done && i_ctl.row_odd;

    // combine the two samples of a row
    assign smp_ext  = PAIR_BITS'(smp);
    assign part_ext = PAIR_BITS'(r_pair_partial);
    assign pair_sum = part_ext + smp_ext;
    assign pair_max = (smp_ext > part_ext) ? smp_ext : part_ext;
    assign pair     = (i_mode == MODE_AVG) ? pair_sum : pair_max;

    // combine with the stored upper pair
    assign tot     = TOT_BITS'(r_up) + TOT_BITS'(pair);
    assign win_max = (pair > r_up) ? pair : r_up;
    assign res     = (i_mode == MODE_AVG) ? tot[TOT_BITS-1:2] : win_max[SAMPLE_BITS-1:0];

    // store write and registered read of the current slot
    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_up <= r_store[addr];
            if (wr_upper) begin
                r_store[addr] <= pair;
            end
        end
    end

    // first sample of a pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_partial <= '0;
        end else if (o_accept && i_ctl.in_win && !i_ctl.col_odd) begin
            r_pair_partial <= smp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_accept && o_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pool.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept && o_emit) begin
            r_pooled <= res;
            r_last   <= i_ctl.last_win;
        end
    end

    assign o_pool.valid        = r_out_valid;
    assign o_pool.pooled_value = r_pooled;
    assign o_pool.last_of_map  = r_last;

endmodule
